// ===== src/wmf_pkg.sv =====
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared widths, register indexes and controller/datapath interface types for
// the window median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int RAD_REG_W  = 2;
  // sized for the largest supported radius (side up to 7)
  localparam int IDX_W      = 4;
  localparam int BIT_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  typedef struct packed {
    logic                 accept;    // take the request, advance position
    logic                 rd_issue;  // read line store for window row
    logic                 sh_row;    // shift window row with line data
    logic                 wr;        // shift last row with pixel, store pixel
    logic                 sel_step;  // count one window row for current bit
    logic                 sel_last;  // last row of this bit: resolve bit
    logic                 out_load;  // move result to output register
    logic [IDX_W-1:0]     row_idx;
    logic [BIT_IDX_W-1:0] bit_idx;
  } wmf_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] span;     // 2 * radius of the item in work
    logic             emit;     // item produces a result
    logic             out_busy; // output register full and stalled
  } wmf_status_t;

endpackage

// ===== src/wmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// wmf_ctrl
// Sequencer: line reads, window shift, pixel store, bitwise median select.
// ----------------------------------------------------------------------------
module wmf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wmf_pkg::wmf_status_t status,
  output wmf_pkg::wmf_cmd_t    cmd
);
  import wmf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_SH, ST_WR, ST_SEL, ST_DONE
  } state_t;

  state_t               state_r;
  logic [IDX_W-1:0]     row_r;
  logic [BIT_IDX_W-1:0] bit_r;
  logic [IDX_W-1:0]     side_m1;

  assign side_m1  = status.span; // side - 1
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.row_idx  = row_r;
    cmd.bit_idx  = bit_r;
    unique case (state_r)
      ST_IDLE: cmd.accept   = in_valid;
      ST_RD:   cmd.rd_issue = 1'b1;
      ST_SH:   cmd.sh_row   = 1'b1;
      ST_WR: begin
        cmd.wr      = 1'b1;
        cmd.row_idx = status.span;
      end
      ST_SEL: begin
        cmd.sel_step = 1'b1;
        cmd.sel_last = (row_r == side_m1);
      end
      ST_DONE: cmd.out_load = !status.out_busy;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      bit_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          row_r <= '0;
          if (in_valid) state_r <= ST_RD;
        end
        ST_RD: begin
          // radius zero: no line rows to fetch
          if (status.span == '0) state_r <= ST_WR;
          else state_r <= ST_SH;
        end
        ST_SH: begin
          if (row_r == status.span - 1'b1) begin
            state_r <= ST_WR;
          end else begin
            row_r   <= row_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        ST_WR: begin
          row_r <= '0;
          bit_r <= BIT_IDX_W'(PIX_W - 1);
          state_r <= status.emit ? ST_SEL : ST_IDLE;
        end
        ST_SEL: begin
          if (row_r == side_m1) begin
            row_r <= '0;
            if (bit_r == '0) state_r <= ST_DONE;
            else bit_r <= bit_r - 1'b1;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end
        ST_DONE: if (!status.out_busy) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but next not stalled");

  a_sel_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEL) |-> (row_r <= side_m1))
    else $error("select row beyond window side");

  a_rd_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SH) |-> (row_r < status.span))
    else $error("line read row beyond span");

endmodule

// ===== src/wmf_datapath.sv =====
// ----------------------------------------------------------------------------
// wmf_datapath
// Position counters, line store, window registers, bitwise median select
// and the output register.
// ----------------------------------------------------------------------------
module wmf_datapath #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_RADIUS = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wmf_pkg::wmf_cmd_t                  cmd,
  output wmf_pkg::wmf_status_t               status,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_c,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height_c,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]    radius_c,
  input  logic [wmf_pkg::PIX_W-1:0]          in_pixel_value,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [wmf_pkg::PIX_W-1:0]          out_median_value,
  output logic [wmf_pkg::POS_W-1:0]          out_center_row,
  output logic [wmf_pkg::POS_W-1:0]          out_center_col,
  output logic                               out_frame_last
);
  import wmf_pkg::*;

  localparam int NL   = 2 * MAX_RADIUS;
  localparam int WS   = 2 * MAX_RADIUS + 1;
  localparam int WIW  = $clog2(WS);
  localparam int LW   = (NL > 1) ? $clog2(NL) : 1;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int XW   = WW + 1;
  localparam int YW   = HW + 1;
  localparam int RDW  = $clog2(MAX_RADIUS + 1);
  localparam int AD   = $clog2(NL * MAX_WIDTH);
  localparam int CNTW = $clog2(WS * WS + 1);

  // position of the next pixel
  logic [CW-1:0]    col_count_r;
  logic [RW-1:0]    row_count_r;
  logic [LW-1:0]    slot_count_r;
  // item in work
  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  logic [LW-1:0]    base_r;
  logic [RDW-1:0]   rad_r;
  logic [IDX_W-1:0] span_r;
  logic [PIX_W-1:0] pix_r;
  logic             emit_r;
  logic             last_r;

  logic [PIX_W-1:0] mem [NL*MAX_WIDTH];
  logic [PIX_W-1:0] rdata_r;
  logic [PIX_W-1:0] win_r [WS][WS];

  logic [PIX_W-1:0] prefix_r;
  logic [CNTW-1:0]  k_r;
  logic [CNTW-1:0]  acc_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_med_r;
  logic [POS_W-1:0] out_row_r;
  logic [POS_W-1:0] out_col_r;
  logic             out_last_r;

  // pre-wrap / post-advance position arithmetic
  logic [XW-1:0]    c0, cn;
  logic [YW-1:0]    r0, rn;
  logic [LW-1:0]    s0, sn;
  logic [IDX_W-1:0] span_in;
  logic [IDX_W-1:0] side_in;
  logic             emit_in;
  logic             last_in;

  always_comb begin
    c0 = XW'(col_count_r);
    r0 = YW'(row_count_r);
    s0 = slot_count_r;
    if (c0 >= XW'(width_c)) begin
      c0 = '0;
      r0 = r0 + 1'b1;
      s0 = (s0 == LW'(NL - 1)) ? '0 : s0 + 1'b1;
    end
    if (r0 >= YW'(height_c)) begin
      r0 = '0;
      s0 = '0;
    end
    cn = c0 + 1'b1;
    rn = r0;
    sn = s0;
    if (cn >= XW'(width_c)) begin
      cn = '0;
      rn = r0 + 1'b1;
      sn = (s0 == LW'(NL - 1)) ? '0 : s0 + 1'b1;
      if (rn >= YW'(height_c)) begin
        rn = '0;
        sn = '0;
      end
    end
    span_in = IDX_W'({radius_c, 1'b0});
    side_in = span_in + 1'b1;
    emit_in = (r0 >= YW'(span_in)) && (c0 >= XW'(span_in));
    last_in = (r0 == YW'(height_c) - 1'b1) && (c0 == XW'(width_c) - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r  <= '0;
      row_count_r  <= '0;
      slot_count_r <= '0;
      emit_r       <= 1'b0;
      span_r       <= '0;
    end else if (cmd.accept) begin
      col_count_r  <= CW'(cn);
      row_count_r  <= RW'(rn);
      slot_count_r <= sn;
      emit_r       <= emit_in;
      span_r       <= span_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      col_r    <= CW'(c0);
      row_r    <= RW'(r0);
      base_r   <= s0;
      rad_r    <= radius_c;
      pix_r    <= in_pixel_value;
      last_r   <= last_in;
    end
  end

  // line store: one read, one write port
  logic [AD-1:0] rd_addr, wr_addr;
  int            slot_tmp;

  always_comb begin
    slot_tmp = int'(base_r) + NL - (int'(span_r) - int'(cmd.row_idx));
    if (slot_tmp >= NL) slot_tmp = slot_tmp - NL;
    rd_addr = AD'(slot_tmp * MAX_WIDTH + int'(col_r));
    wr_addr = AD'(int'(base_r) * MAX_WIDTH + int'(col_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rdata_r <= mem[rd_addr];
    if (cmd.wr) mem[wr_addr] <= pix_r;
  end

  // window row shift
  logic [WIW-1:0]   ri;
  logic [PIX_W-1:0] ext [WS+1];
  logic [PIX_W-1:0] row_nxt [WS];
  logic [PIX_W-1:0] nv;

  assign ri = cmd.row_idx[WIW-1:0];
  assign nv = cmd.sh_row ? rdata_r : pix_r;

  always_comb begin
    for (int dx = 0; dx < WS; dx++) ext[dx] = win_r[ri][dx];
    ext[WS] = '0;
    for (int dx = 0; dx < WS; dx++) begin
      if (dx == int'(span_r)) row_nxt[dx] = nv;
      else if (dx < int'(span_r)) row_nxt[dx] = ext[dx+1];
      else row_nxt[dx] = ext[dx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int y = 0; y < WS; y++)
        for (int x = 0; x < WS; x++) win_r[y][x] <= '0;
    end else if (cmd.sh_row || cmd.wr) begin
      for (int x = 0; x < WS; x++) win_r[ri][x] <= row_nxt[x];
    end
  end

  // bitwise rank select: one window row per cycle, MSB first
  logic [PIX_W-1:0] bit_mask;
  logic [CNTW-1:0]  row_cnt;
  logic [CNTW-1:0]  acc_sum;

  always_comb begin
    bit_mask = {PIX_W{1'b1}} << cmd.bit_idx;
    row_cnt  = '0;
    for (int dx = 0; dx < WS; dx++) begin
      if (dx <= int'(span_r) && (((win_r[ri][dx] ^ prefix_r) & bit_mask) == '0))
        row_cnt = row_cnt + 1'b1;
    end
    acc_sum = acc_r + row_cnt;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prefix_r <= '0;
      acc_r    <= '0;
      k_r      <= CNTW'((int'(side_in) * int'(side_in)) / 2);
    end else if (cmd.sel_step) begin
      if (cmd.sel_last) begin
        acc_r <= '0;
        if (k_r >= acc_sum) begin
          prefix_r[cmd.bit_idx] <= 1'b1;
          k_r <= k_r - acc_sum;
        end
      end else begin
        acc_r <= acc_sum;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_med_r  <= prefix_r;
      out_row_r  <= POS_W'(int'(row_r) - int'(rad_r));
      out_col_r  <= POS_W'(int'(col_r) - int'(rad_r));
      out_last_r <= last_r;
    end
  end

  assign status.span     = span_r;
  assign status.emit     = emit_r;
  assign status.out_busy = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_median_value = out_med_r;
  assign out_center_row   = out_row_r;
  assign out_center_col   = out_col_r;
  assign out_frame_last   = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result loaded over a stalled one");

  a_stalled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_med_r)))
    else $error("stalled result changed");

  a_load_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> emit_r)
    else $error("result for a border pixel");

endmodule

// ===== src/window_median_filter_unit.sv =====
// ----------------------------------------------------------------------------
// window_median_filter_unit
// Streaming 2-D median filter over a square window of side 2r+1.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: gray pixels in raster order, one request per pixel. A request is
//    taken when in_valid is high and in_stall low.
//  - out_*: one result per interior centre pixel (row and column at least r
//    from the top/left edge of the window's far corner), carrying the median
//    and the centre's row/column; out_frame_last marks the frame's final one.
//  - cfg_*: register writes (width, height, radius), always ready. Write only
//    while no request is in flight.
//  - Per pixel: a line-store fetch and window shift for each of the 2r line
//    rows (at radius zero the unused line-store read is still issued), plus,
//    when a result is produced, one bit of the median per pass over the
//    window rows. The single line-store read port and the row-per-cycle rank
//    count set this.
//  - A finished result waits in the output register; the next pixel is
//    still taken and worked on while out_stall holds it, and only the final
//    hand-over waits.
//  - Reset: position at row 0/column 0, window registers zero, registers to
//    512 x 512, radius 1. The line store is not cleared.
// ----------------------------------------------------------------------------
module window_median_filter_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_RADIUS = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [wmf_pkg::PIX_W-1:0]        in_pixel_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [wmf_pkg::PIX_W-1:0]        out_median_value,
  output logic [wmf_pkg::POS_W-1:0]        out_center_row,
  output logic [wmf_pkg::POS_W-1:0]        out_center_col,
  output logic                             out_frame_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wmf_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RDW = $clog2(MAX_RADIUS + 1);

  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  logic [RAD_REG_W-1:0]  radius_r;

  logic [WW-1:0]  width_c;
  logic [HW-1:0]  height_c;
  logic [RDW-1:0] radius_c;

  wmf_cmd_t    cmd;
  wmf_status_t status;

  assign cfg_ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_DATA_W'(512);
      height_r <= CFG_DATA_W'(512);
      radius_r <= RAD_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   width_r  <= cfg_data;
        REG_IMAGE_HEIGHT:  height_r <= cfg_data;
        REG_WINDOW_RADIUS: radius_r <= cfg_data[RAD_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate registers into the supported ranges
  always_comb begin
    if (width_r == '0) width_c = WW'(1);
    else if (int'(width_r) > MAX_WIDTH) width_c = WW'(MAX_WIDTH);
    else width_c = WW'(width_r);
    if (height_r == '0) height_c = HW'(1);
    else if (int'(height_r) > MAX_HEIGHT) height_c = HW'(MAX_HEIGHT);
    else height_c = HW'(height_r);
    if (int'(radius_r) > MAX_RADIUS) radius_c = RDW'(MAX_RADIUS);
    else radius_c = RDW'(radius_r);
  end

  wmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  wmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .width_c          (width_c),
    .height_c         (height_c),
    .radius_c         (radius_c),
    .in_pixel_value   (in_pixel_value),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_median_value (out_median_value),
    .out_center_row   (out_center_row),
    .out_center_col   (out_center_col),
    .out_frame_last   (out_frame_last)
  );

endmodule
